/* rtl/core/wsst_pkg.sv */
// Shared types and constants for the 2D wave stencil step unit.
`default_nettype none
package wsst_pkg;

	localparam int VALUE_W    = 32;
	localparam int GRID_W     = 11;
	localparam int COEFF_W    = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int FRAC_W     = 16;
	localparam int GRID_MIN   = 3;

	// Laplacian of five Q16.16 points, 2*C - P, coeff * Laplacian
	localparam int LAP_W  = VALUE_W + 4;
	localparam int BASE_W = VALUE_W + 3;
	localparam int PROD_W = LAP_W + COEFF_W + 1;
	localparam int TERM_W = PROD_W - FRAC_W;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_WAVE_COEFF = 1'b1;

	localparam logic [GRID_W-1:0]  GRID_RESET  = 11'd100;
	localparam logic [COEFF_W-1:0] COEFF_RESET = 16'd164;

	localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) << (FRAC_W - 1);

	typedef logic signed [VALUE_W-1:0] value_t;

	typedef struct packed {
		value_t cur_value;
		value_t prev_value;
	} in_item_t;

	typedef struct packed {
		value_t new_value;
		logic   last_out;
	} out_item_t;

	// one window column, top is the oldest row
	typedef struct packed {
		value_t top;
		value_t mid;
		value_t bot;
	} col_t;

	typedef struct packed {
		logic signed [LAP_W-1:0]  lap;
		logic signed [BASE_W-1:0] base;
		logic                     interior;
		logic                     last;
	} upd_item_t;

endpackage
`default_nettype wire

/* rtl/core/wsst_stream_if.sv */
// Valid/ready stream channel carrying one payload item per transfer.
`default_nettype none
interface wsst_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/wsst_line_buf.sv */
// Single-port-write, single-port-read line buffer with registered read data.
`default_nettype none
module wsst_line_buf #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* rtl/core/wsst_col_cell.sv */
// One column of the 3-row stencil window; shifts to its older neighbor.
`default_nettype none
module wsst_col_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire wsst_pkg::col_t col_in,
	output wsst_pkg::col_t      col_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (en) begin
			col_q <= col_in;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/wsst_update.sv */
// Update pipeline: coeff multiply, rounding, saturation and result register.
`default_nettype none
module wsst_update #(
	parameter int DATA_BITS = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [wsst_pkg::COEFF_W-1:0]        coeff,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire wsst_pkg::upd_item_t                 item,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output wsst_pkg::out_item_t                      out_item
);

	localparam int SUM_W = ((DATA_BITS > wsst_pkg::TERM_W) ? DATA_BITS : wsst_pkg::TERM_W) + 2;
	localparam logic signed [SUM_W-1:0] SAT_HI =
		{{(SUM_W - DATA_BITS + 1){1'b0}}, {(DATA_BITS - 1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SAT_LO =
		{{(SUM_W - DATA_BITS + 1){1'b1}}, {(DATA_BITS - 1){1'b0}}};

	logic                                   v2_q;
	logic signed [wsst_pkg::LAP_W-1:0]      lap_s2;
	logic signed [wsst_pkg::BASE_W-1:0]     base_s2;
	logic                                   interior_s2;
	logic                                   last_s2;

	logic                                   v3_q;
	logic signed [wsst_pkg::PROD_W-1:0]     prod_s3;
	logic signed [wsst_pkg::BASE_W-1:0]     base_s3;
	logic                                   interior_s3;
	logic                                   last_s3;

	logic                                   go2;
	logic                                   go3;
	logic                                   go_out;
	logic signed [wsst_pkg::COEFF_W:0]      coeff_s;
	logic signed [wsst_pkg::PROD_W-1:0]     rounded;
	logic signed [wsst_pkg::TERM_W-1:0]     term;
	logic signed [SUM_W-1:0]                sum;
	logic signed [SUM_W-1:0]                sat;

	// a stage moves when the one after it is empty or moving
	assign go_out   = !out_valid || out_ready;
	assign go3      = !v3_q || go_out;
	assign go2      = !v2_q || go3;
	assign in_ready = go2;

	assign coeff_s = $signed({1'b0, coeff});
	assign rounded = prod_s3 + wsst_pkg::ROUND_BIAS;
	assign term    = rounded[wsst_pkg::PROD_W-1:wsst_pkg::FRAC_W];
	assign sum     = SUM_W'(base_s3) + SUM_W'(term);
	assign sat     = (sum > SAT_HI) ? SAT_HI : ((sum < SAT_LO) ? SAT_LO : sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q      <= 1'b0;
			v3_q      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (go2) begin
				v2_q <= in_valid;
			end
			if (go3) begin
				v3_q <= v2_q;
			end
			if (go_out) begin
				out_valid <= v3_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go2 && in_valid) begin
			lap_s2      <= item.lap;
			base_s2     <= item.base;
			interior_s2 <= item.interior;
			last_s2     <= item.last;
		end
		if (go3 && v2_q) begin
			prod_s3     <= wsst_pkg::PROD_W'(coeff_s) * wsst_pkg::PROD_W'(lap_s2);
			base_s3     <= base_s2;
			interior_s3 <= interior_s2;
			last_s3     <= last_s2;
		end
		if (go_out && v3_q) begin
			// fixed edges: boundary points give zero
			out_item.new_value <= interior_s3 ? sat[wsst_pkg::VALUE_W-1:0] : '0;
			out_item.last_out  <= last_s3;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/wave2d_stencil_step_unit.sv */
// Top level: one time step of the 2D wave equation over a streamed square grid.
//
//  channel  | dir | payload                      | transfer
//  ---------+-----+------------------------------+-------------------------
//  points   | in  | cur_value, prev_value        | valid & ready
//  results  | out | new_value, last_out          | valid & ready
//  cfg      | in  | cfg_idx, cfg_wdata           | cfg_we
//
// One point per cycle sustained while results are taken; the result for point k - grid - 1
// passes the read, Laplacian, multiply and output registers after point k's transfer edge.
// Row buffers and the previous-plane delay are block RAMs with one write and one
// read port each; no clearing pass after reset, points are taken at once.
// A stall on results fills the four internal stages, then drops points.ready.
`default_nettype none
module wave2d_stencil_step_unit #(
	parameter int MAX_GRID  = 1024,
	parameter int DATA_BITS = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [wsst_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [wsst_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	wsst_stream_if.sink                            points,
	wsst_stream_if.source                          results
);

	localparam int AW = $clog2(MAX_GRID);
	localparam int GW = (AW + 1 > wsst_pkg::GRID_W) ? AW + 1 : wsst_pkg::GRID_W;
	localparam int NCELLS = 2;

	logic [wsst_pkg::GRID_W-1:0]   grid_q;
	logic [wsst_pkg::COEFF_W-1:0]  coeff_q;
	logic [AW-1:0]                 row_q;
	logic [AW-1:0]                 col_q;

	logic [GW-1:0]                 grid_ext;
	logic [GW-1:0]                 g;
	logic [AW-1:0]                 r;
	logic [AW-1:0]                 c;
	logic                          c_end;
	logic                          r_end;
	logic                          accept;
	logic                          adv1;

	logic                          v1_q;
	wsst_pkg::value_t              cur_s1;
	wsst_pkg::value_t              prv_s1;
	logic [AW-1:0]                 col_s1;
	logic                          emit_s1;
	logic                          interior_s1;
	logic                          last_s1;

	wsst_pkg::value_t              above_rd;
	wsst_pkg::value_t              center_rd;
	wsst_pkg::value_t              pline_rd;
	wsst_pkg::value_t              pdel_q;

	wsst_pkg::col_t                cell_in [NCELLS];
	wsst_pkg::col_t                cell_q  [NCELLS];

	wsst_pkg::upd_item_t           upd_item;
	logic                          upd_valid;
	logic                          upd_ready;
	logic                          res_valid;
	wsst_pkg::out_item_t           res_item;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q  <= wsst_pkg::GRID_RESET;
			coeff_q <= wsst_pkg::COEFF_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				wsst_pkg::CFG_GRID_SIZE:  grid_q  <= cfg_wdata[wsst_pkg::GRID_W-1:0];
				wsst_pkg::CFG_WAVE_COEFF: coeff_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// effective side, clamped to the supported range
	assign grid_ext = GW'(grid_q);
	assign g = (grid_ext < GW'(wsst_pkg::GRID_MIN)) ? GW'(wsst_pkg::GRID_MIN) :
	           ((grid_ext > GW'(MAX_GRID)) ? GW'(MAX_GRID) : grid_ext);

	// a counter left beyond a smaller size restarts at zero
	assign r     = (GW'(row_q) >= g) ? '0 : row_q;
	assign c     = (GW'(col_q) >= g) ? '0 : col_q;
	assign c_end = (GW'(c) == g - GW'(1));
	assign r_end = (GW'(r) == g - GW'(1));

	assign accept        = points.valid && points.ready;
	assign adv1          = v1_q && (!emit_s1 || upd_ready);
	assign points.ready  = !v1_q || adv1;
	assign upd_valid     = v1_q && emit_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			v1_q  <= 1'b0;
		end else begin
			if (accept) begin
				if (c_end) begin
					col_q <= '0;
					row_q <= r_end ? '0 : r + AW'(1);
				end else begin
					col_q <= c + AW'(1);
				end
			end
			if (points.ready) begin
				v1_q <= points.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_s1      <= points.data.cur_value;
			prv_s1      <= points.data.prev_value;
			col_s1      <= c;
			emit_s1     <= (r >= AW'(2)) || ((r == AW'(1)) && (c >= AW'(1)));
			interior_s1 <= (r >= AW'(2)) && (c >= AW'(2));
			last_s1     <= r_end && c_end;
		end
		if (adv1) begin
			pdel_q <= pline_rd;
		end
	end

	// read at the new point's column, write back when that point leaves stage 1
	wsst_line_buf #(.DEPTH(MAX_GRID), .WIDTH(wsst_pkg::VALUE_W)) u_row_above (
		.clk   (clk),
		.we    (adv1),
		.waddr (col_s1),
		.wdata (center_rd),
		.re    (accept),
		.raddr (c),
		.rdata (above_rd)
	);

	wsst_line_buf #(.DEPTH(MAX_GRID), .WIDTH(wsst_pkg::VALUE_W)) u_row_center (
		.clk   (clk),
		.we    (adv1),
		.waddr (col_s1),
		.wdata (cur_s1),
		.re    (accept),
		.raddr (c),
		.rdata (center_rd)
	);

	wsst_line_buf #(.DEPTH(MAX_GRID), .WIDTH(wsst_pkg::VALUE_W)) u_prev_line (
		.clk   (clk),
		.we    (adv1),
		.waddr (col_s1),
		.wdata (prv_s1),
		.re    (accept),
		.raddr (c),
		.rdata (pline_rd)
	);

	// window columns, newest first
	assign cell_in[0] = '{top: above_rd, mid: center_rd, bot: cur_s1};

	for (genvar i = 0; i < NCELLS; i++) begin : g_cells
		if (i > 0) begin : g_link
			assign cell_in[i] = cell_q[i-1];
		end
		wsst_col_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv1),
			.col_in (cell_in[i]),
			.col_q  (cell_q[i])
		);
	end

	// Laplacian of the two held columns and this point's column, before this point's shift
	assign upd_item.lap =
		wsst_pkg::LAP_W'(cell_q[0].top) + wsst_pkg::LAP_W'(cell_q[0].bot) +
		wsst_pkg::LAP_W'(cell_q[1].mid) + wsst_pkg::LAP_W'(center_rd) -
		(wsst_pkg::LAP_W'(cell_q[0].mid) <<< 2);
	assign upd_item.base =
		(wsst_pkg::BASE_W'(cell_q[0].mid) <<< 1) - wsst_pkg::BASE_W'(pdel_q);
	assign upd_item.interior = interior_s1;
	assign upd_item.last     = last_s1;

	wsst_update #(.DATA_BITS(DATA_BITS)) u_update (
		.clk       (clk),
		.arst_n    (arst_n),
		.coeff     (coeff_q),
		.in_valid  (upd_valid),
		.in_ready  (upd_ready),
		.item      (upd_item),
		.out_valid (res_valid),
		.out_ready (results.ready),
		.out_item  (res_item)
	);

	assign results.valid = res_valid;
	assign results.data  = res_item;

	a_no_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(adv1 && accept) |-> (col_s1 != c))
		else $error("line buffer write and read hit the same column");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && !results.ready) |=> (results.valid && $stable(results.data)))
		else $error("waiting result changed or dropped");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v1_q)
		else $error("accepted point missing from stage 1");

endmodule
`default_nettype wire
